// ===== rtl/core/ffea_pkg.sv =====
package ffea_pkg;

    // Fixed widths of the request and response fields.
    localparam int unsigned FieldBits = 32;
    localparam int unsigned CountBits = 7;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Update strobes broadcast to every cell of the extent chain.
    typedef struct packed {
        logic set_en;
        logic drop_en;
        logic ins_en;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ffea_if.sv =====
interface ffea_req_if import ffea_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [FieldBits-1:0] region_start;
    logic [FieldBits-1:0] region_length;

    modport source (output valid, req_type, region_start, region_length, input ready);
    modport sink (input valid, req_type, region_start, region_length, output ready);
    modport monitor (input valid, ready, req_type, region_start, region_length);
endinterface

interface ffea_rsp_if import ffea_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FieldBits-1:0] granted_start;
    logic [1:0]           status;
    logic [FieldBits-1:0] end_mark;
    logic [CountBits-1:0] free_extent_count;

    modport source (output valid, granted_start, status, end_mark, free_extent_count,
                    input ready);
    modport sink (input valid, granted_start, status, end_mark, free_extent_count,
                  output ready);
    modport monitor (input valid, ready, granted_start, status, end_mark,
                     free_extent_count);
endinterface

// ===== rtl/core/first_fit_extent_allocator_top.sv =====
// Flow: a request passes through the compare, decide and update states (S_CMP, S_DEC,
// S_APP) before its response is registered. A new request is taken only in S_IDLE, after
// the update of the last one through the extent cell chain; a waiting response does not
// block acceptance unless a second response is ready to be written.
// Reset: synchronous, active low; clears the extent count, end mark and handshake state.
module first_fit_extent_allocator_top
    import ffea_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS = 64,
    parameter int unsigned ADDR_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffea_req_if.sink   i_req,
    ffea_rsp_if.source o_rsp
);

    localparam int unsigned W  = (ADDR_BITS > FieldBits) ? ADDR_BITS : FieldBits;
    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [W:0] AddrMax = ((W+1)'(1) << ADDR_BITS) - (W+1)'(1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_DEC  = 4'b0100,
        S_APP  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Request hold registers.
    logic         r_req_type;
    logic [W-1:0] r_req_start;
    logic [W-1:0] r_req_len;

    // Allocator state.
    logic [CW-1:0] r_count;
    logic [W-1:0]  r_end_mark;

    // Decision registers.
    t_cell_ctl     r_ctl, n_ctl;
    logic [IW-1:0] r_set_idx, n_set_idx;
    logic [W-1:0]  r_set_start, n_set_start;
    logic [W-1:0]  r_set_len, n_set_len;
    logic [IW-1:0] r_drop_idx, n_drop_idx;
    logic [CW-1:0] r_new_count, n_new_count;
    logic [W-1:0]  r_new_end, n_new_end;
    logic [W-1:0]  r_granted, n_granted;
    t_status       r_status, n_status;

    // Response register.
    logic                 r_out_valid;
    logic [FieldBits-1:0] r_out_granted;
    logic [1:0]           r_out_status;
    logic [FieldBits-1:0] r_out_end;
    logic [CountBits-1:0] r_out_count;

    logic      w_commit;
    t_cell_ctl w_ctl;

    logic [W-1:0] c_start [MAX_EXTENTS];
    logic [W-1:0] c_len   [MAX_EXTENTS];
    logic [W:0]   c_end   [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] c_fit;
    logic [MAX_EXTENTS-1:0] c_lt;

    assign w_commit = (r_state == S_APP) && (!r_out_valid || o_rsp.ready);
    assign w_ctl    = w_commit ? r_ctl : '0;

    // Chain of extent cells linked to their neighbors; an end cell links to itself.
    for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
        localparam int unsigned LeftPos  = (k == 0) ? 0 : k - 1;
        localparam int unsigned RightPos = (k == MAX_EXTENTS - 1) ? k : k + 1;
        ffea_cell #(.W(W), .IW(IW), .CW(CW), .POS(k)) u_cell (
            .i_clk         (i_clk),
            .i_req_start   (r_req_start),
            .i_req_len     (r_req_len),
            .i_count       (r_count),
            .i_ctl         (w_ctl),
            .i_set_idx     (r_set_idx),
            .i_set_start   (r_set_start),
            .i_set_len     (r_set_len),
            .i_drop_idx    (r_drop_idx),
            .i_left_start  (c_start[LeftPos]),
            .i_left_len    (c_len[LeftPos]),
            .i_right_start (c_start[RightPos]),
            .i_right_len   (c_len[RightPos]),
            .o_start       (c_start[k]),
            .o_len         (c_len[k]),
            .o_end         (c_end[k]),
            .o_fit         (c_fit[k]),
            .o_lt          (c_lt[k])
        );
    end

    // Locate the first fit, the predecessor and the successor of a freed range.
    logic [MAX_EXTENTS-1:0] w_fit_oh, w_prev_oh, w_next_oh;
    logic [IW-1:0]          w_fit_idx, w_prev_idx;
    logic [W-1:0]           w_fit_start, w_fit_len, w_prev_start, w_prev_len;
    logic [W-1:0]           w_next_start, w_next_len;
    logic [W:0]             w_prev_end;

    always_comb begin
        w_fit_oh = c_fit & (~c_fit + MAX_EXTENTS'(1));
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            w_prev_oh[k] = c_lt[k] && ((k == MAX_EXTENTS - 1) || !c_lt[(k + 1) % MAX_EXTENTS]);
            w_next_oh[k] = (CW'(k) < r_count) && !c_lt[k]
                           && ((k == 0) || c_lt[(k + MAX_EXTENTS - 1) % MAX_EXTENTS]);
        end
        w_fit_idx = '0;
        w_prev_idx = '0;
        w_fit_start = '0;
        w_fit_len = '0;
        w_prev_start = '0;
        w_prev_len = '0;
        w_prev_end = '0;
        w_next_start = '0;
        w_next_len = '0;
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            if (w_fit_oh[k]) begin
                w_fit_idx   = w_fit_idx | IW'(k);
                w_fit_start = w_fit_start | c_start[k];
                w_fit_len   = w_fit_len | c_len[k];
            end
            if (w_prev_oh[k]) begin
                w_prev_idx   = w_prev_idx | IW'(k);
                w_prev_start = w_prev_start | c_start[k];
                w_prev_len   = w_prev_len | c_len[k];
                w_prev_end   = w_prev_end | c_end[k];
            end
            if (w_next_oh[k]) begin
                w_next_start = w_next_start | c_start[k];
                w_next_len   = w_next_len | c_len[k];
            end
        end
    end

    // Decide the table update and the response.
    logic       w_has_prev, w_has_next, w_left, w_right;
    logic [W:0] w_free_end, w_alloc_sum;
    logic [IW:0] w_pos;

    always_comb begin
        w_has_prev  = |c_lt;
        w_has_next  = |w_next_oh;
        w_free_end  = {1'b0, r_req_start} + {1'b0, r_req_len};
        w_alloc_sum = {1'b0, r_end_mark} + {1'b0, r_req_len};
        w_pos       = w_has_prev ? ({1'b0, w_prev_idx} + (IW+1)'(1)) : '0;
        w_left      = w_has_prev && (w_prev_end == {1'b0, r_req_start});
        w_right     = w_has_next && ({1'b0, w_next_start} == w_free_end);

        n_ctl       = '0;
        n_set_idx   = '0;
        n_set_start = '0;
        n_set_len   = '0;
        n_drop_idx  = '0;
        n_new_count = r_count;
        n_new_end   = r_end_mark;
        n_granted   = '0;
        n_status    = ST_OK;

        if (r_req_type == REQ_ALLOC) begin
            if (r_req_len == '0) begin
                n_granted = r_end_mark;
            end else if (|c_fit) begin
                n_granted = w_fit_start;
                if (w_fit_len == r_req_len) begin
                    n_ctl.drop_en = 1'b1;
                    n_drop_idx    = w_fit_idx;
                    n_new_count   = r_count - CW'(1);
                end else begin
                    n_ctl.set_en = 1'b1;
                    n_set_idx    = w_fit_idx;
                    n_set_start  = w_fit_start + r_req_len;
                    n_set_len    = w_fit_len - r_req_len;
                end
            end else if (w_alloc_sum > AddrMax) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_granted = r_end_mark;
                n_new_end = w_alloc_sum[W-1:0];
            end
        end else begin
            priority if ((r_req_len == '0) || (w_free_end > {1'b0, r_end_mark})
                         || (w_has_prev && (w_prev_end > {1'b0, r_req_start}))
                         || (w_has_next && ({1'b0, w_next_start} < w_free_end))) begin
                n_status = ST_REJECT;
            end else if (w_free_end == {1'b0, r_end_mark}) begin
                if (w_left) begin
                    n_new_end     = w_prev_start;
                    n_ctl.drop_en = 1'b1;
                    n_drop_idx    = w_prev_idx;
                    n_new_count   = r_count - CW'(1);
                end else begin
                    n_new_end = r_req_start;
                end
            end else if (w_left && w_right) begin
                n_ctl.set_en  = 1'b1;
                n_set_idx     = w_prev_idx;
                n_set_start   = w_prev_start;
                n_set_len     = w_prev_len + r_req_len + w_next_len;
                n_ctl.drop_en = 1'b1;
                n_drop_idx    = w_pos[IW-1:0];
                n_new_count   = r_count - CW'(1);
            end else if (w_left) begin
                n_ctl.set_en = 1'b1;
                n_set_idx    = w_prev_idx;
                n_set_start  = w_prev_start;
                n_set_len    = w_prev_len + r_req_len;
            end else if (w_right) begin
                n_ctl.set_en = 1'b1;
                n_set_idx    = w_pos[IW-1:0];
                n_set_start  = r_req_start;
                n_set_len    = w_next_len + r_req_len;
            end else if (r_count >= CW'(MAX_EXTENTS)) begin
                n_status = ST_FULL;
            end else begin
                n_ctl.set_en = 1'b1;
                n_ctl.ins_en = 1'b1;
                n_set_idx    = w_pos[IW-1:0];
                n_set_start  = r_req_start;
                n_set_len    = r_req_len;
                n_new_count  = r_count + CW'(1);
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_CMP;
            S_CMP:  n_state = S_DEC;
            S_DEC:  n_state = S_APP;
            S_APP:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_end_mark  <= '0;
            r_out_valid <= 1'b0;
            r_ctl       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DEC) begin
                r_ctl <= n_ctl;
            end
            if (w_commit) begin
                r_count     <= r_new_count;
                r_end_mark  <= r_new_end;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    logic [CW+CountBits-1:0] w_count_ext;
    assign w_count_ext = {{CountBits{1'b0}}, r_new_count};

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type  <= i_req.req_type;
            r_req_start <= W'(i_req.region_start);
            r_req_len   <= W'(i_req.region_length);
        end
        if (r_state == S_DEC) begin
            r_set_idx   <= n_set_idx;
            r_set_start <= n_set_start;
            r_set_len   <= n_set_len;
            r_drop_idx  <= n_drop_idx;
            r_new_count <= n_new_count;
            r_new_end   <= n_new_end;
            r_granted   <= n_granted;
            r_status    <= n_status;
        end
        if (w_commit) begin
            r_out_granted <= r_granted[FieldBits-1:0];
            r_out_status  <= r_status;
            r_out_end     <= r_new_end[FieldBits-1:0];
            r_out_count   <= w_count_ext[CountBits-1:0];
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.granted_start     = r_out_granted;
    assign o_rsp.status            = r_out_status;
    assign o_rsp.end_mark          = r_out_end;
    assign o_rsp.free_extent_count = r_out_count;

endmodule

// ===== rtl/core/ffea_cell.sv =====
module ffea_cell
    import ffea_pkg::*;
#(
    parameter int unsigned W   = 32,
    parameter int unsigned IW  = 6,
    parameter int unsigned CW  = 7,
    parameter int unsigned POS = 0
) (
    input  logic            i_clk,
    input  logic [W-1:0]    i_req_start,
    input  logic [W-1:0]    i_req_len,
    input  logic [CW-1:0]   i_count,
    input  t_cell_ctl       i_ctl,
    input  logic [IW-1:0]   i_set_idx,
    input  logic [W-1:0]    i_set_start,
    input  logic [W-1:0]    i_set_len,
    input  logic [IW-1:0]   i_drop_idx,
    input  logic [W-1:0]    i_left_start,
    input  logic [W-1:0]    i_left_len,
    input  logic [W-1:0]    i_right_start,
    input  logic [W-1:0]    i_right_len,
    output logic [W-1:0]    o_start,
    output logic [W-1:0]    o_len,
    output logic [W:0]      o_end,
    output logic            o_fit,
    output logic            o_lt
);

    logic [W-1:0] r_start;
    logic [W-1:0] r_len;
    logic [W:0]   r_end;
    logic         r_fit;
    logic         r_lt;
    logic         w_valid;

    assign w_valid = CW'(POS) < i_count;

    // Compare this extent against the pending request every cycle.
    always_ff @(posedge i_clk) begin
        r_fit <= w_valid && (r_len >= i_req_len);
        r_lt  <= w_valid && (r_start < i_req_start);
        r_end <= {1'b0, r_start} + {1'b0, r_len};
    end

    // Take a new value, the right neighbor's (removal) or the left neighbor's (insertion).
    always_ff @(posedge i_clk) begin
        if (i_ctl.set_en && (IW'(POS) == i_set_idx)) begin
            r_start <= i_set_start;
            r_len   <= i_set_len;
        end else if (i_ctl.drop_en && (IW'(POS) >= i_drop_idx)) begin
            r_start <= i_right_start;
            r_len   <= i_right_len;
        end else if (i_ctl.ins_en && (IW'(POS) > i_set_idx)) begin
            r_start <= i_left_start;
            r_len   <= i_left_len;
        end
    end

    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_end   = r_end;
    assign o_fit   = r_fit;
    assign o_lt    = r_lt;

endmodule

// ===== rtl/core/ffea_chk.sv =====
module ffea_chk
    import ffea_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [FieldBits-1:0] i_out_granted,
    input logic [1:0]           i_out_status
);

    // A response that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("response dropped before transfer");

    // One request is processed at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // A failed request never grants an offset.
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != ST_OK)) |-> (i_out_granted == '0))
        else $error("offset granted with error status");

    // No response appears in the cycle right after a request transfer.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("response earlier than the pipeline allows");

endmodule

bind first_fit_extent_allocator_top ffea_chk u_ffea_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_granted (o_rsp.granted_start),
    .i_out_status  (o_rsp.status)
);
